// ===== hdl/sle_pkg.sv =====
`default_nettype none

package sle_pkg;

   // Number of cells in the chain; one list entry per cell.
   localparam int DEPTH = 32;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = 6;
   localparam int POS_W = 6;
   localparam int DATA_W = 32;

   // Action codes of the request channel.
   typedef enum logic [2:0] {
      ACT_INSERT = 3'd0,
      ACT_DELETE = 3'd1,
      ACT_LOCATE = 3'd2,
      ACT_GET    = 3'd3,
      ACT_PRED   = 3'd4,
      ACT_SUCC   = 3'd5,
      ACT_CLEAR  = 3'd6
   } action_type;

   // Status codes of the response channel.
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   // What a cell loads at the next clock edge.
   typedef enum logic [1:0] {
      SEL_HOLD  = 2'd0,
      SEL_LEFT  = 2'd1,
      SEL_RIGHT = 2'd2,
      SEL_VALUE = 2'd3
   } cell_sel_type;

   // Control handed to each cell: load select and the request value, which is
   // both the insert data and the search key.
   typedef struct packed {
      cell_sel_type             sel;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

   // Register index of the configuration port.
   localparam logic REG_CAPACITY = 1'b0;

endpackage

`default_nettype wire

// ===== hdl/sequential_list_engine.sv =====
`default_nettype none

// Channel    Direction  Handshake           Payload
// req_       in         req_valid/stall     action, position, value
// rsp_       out        rsp_valid/stall     status, data_out, found_index, entry_count
// csr (APB)  in/out     psel/penable/pready capacity at address 0
//
// A request is executed in the cycle it is accepted; its response is
// registered and shows in the next cycle; one transaction per cycle while not stalled.
// All cells shift, load and compare in parallel in that cycle.
// Reset empties the list and sets capacity to 32; cell contents are not reset.
// A response held by rsp_stall stalls the request side only while it waits.

module sequential_list_engine (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [2:0]                        req_action,
   input  wire logic [sle_pkg::POS_W-1:0]         req_position,
   input  wire logic signed [sle_pkg::DATA_W-1:0] req_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [1:0]                             rsp_status,
   output logic signed [sle_pkg::DATA_W-1:0]      rsp_data_out,
   output logic [4:0]                             rsp_found_index,
   output logic [sle_pkg::CNT_W-1:0]              rsp_entry_count,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [2:0]                        paddr,
   input  wire logic [31:0]                       pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);

   localparam logic [sle_pkg::CNT_W:0] DEPTH_C = (sle_pkg::CNT_W + 1)'(sle_pkg::DEPTH);

   logic                              accept;
   logic [sle_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [sle_pkg::CNT_W-1:0]         capacity_ff, capacity_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [1:0]                        rsp_status_ff, rsp_status_in;
   logic signed [sle_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [4:0]                        rsp_found_ff, rsp_found_in;
   logic [sle_pkg::CNT_W-1:0]         rsp_count_ff;

   logic [sle_pkg::CNT_W:0]           pos_x, count_x, cap_eff;
   logic [sle_pkg::CNT_W:0]           rd_addr;
   logic                              ins_ok, del_ok, do_clear, do_read;
   logic [1:0]                        status;
   sle_pkg::action_type               act;

   logic signed [sle_pkg::DATA_W-1:0] cell_entry [sle_pkg::DEPTH];
   logic [sle_pkg::DEPTH-1:0]         cell_match;
   sle_pkg::cell_ctrl_type            cell_ctrl  [sle_pkg::DEPTH];
   logic                              hit;
   logic [sle_pkg::IDX_W-1:0]         hit_idx;

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign act       = sle_pkg::action_type'(req_action);

   // Widened operands for the bound checks.
   assign pos_x   = {1'b0, req_position};
   assign count_x = {1'b0, count_ff};
   assign cap_eff = ({1'b0, capacity_ff} > DEPTH_C) ? DEPTH_C : {1'b0, capacity_ff};

   // Decode the action into a status, the list update and the read address.
   always_comb begin
      ins_ok   = 1'b0;
      del_ok   = 1'b0;
      do_clear = 1'b0;
      do_read  = 1'b0;
      rd_addr  = pos_x;
      status   = sle_pkg::ST_OK;
      unique case (act)
         sle_pkg::ACT_INSERT: begin
            if (pos_x > count_x) begin
               status = sle_pkg::ST_RANGE;
            end else if (count_x >= cap_eff) begin
               status = sle_pkg::ST_FULL;
            end else begin
               ins_ok = 1'b1;
            end
         end
         sle_pkg::ACT_DELETE: begin
            if (pos_x >= count_x) begin
               status = sle_pkg::ST_RANGE;
            end else begin
               del_ok = 1'b1;
            end
         end
         sle_pkg::ACT_LOCATE: begin
            status = hit ? sle_pkg::ST_OK : sle_pkg::ST_MISSING;
         end
         sle_pkg::ACT_GET: begin
            if (pos_x >= count_x) begin
               status = sle_pkg::ST_RANGE;
            end else begin
               do_read = 1'b1;
            end
         end
         sle_pkg::ACT_PRED: begin
            rd_addr = pos_x - 1'b1;
            if (pos_x == '0 || pos_x >= count_x) begin
               status = sle_pkg::ST_RANGE;
            end else begin
               do_read = 1'b1;
            end
         end
         sle_pkg::ACT_SUCC: begin
            rd_addr = pos_x + 1'b1;
            if (pos_x + 1'b1 >= count_x) begin
               status = sle_pkg::ST_RANGE;
            end else begin
               do_read = 1'b1;
            end
         end
         sle_pkg::ACT_CLEAR: begin
            do_clear = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // The chain of cells, each told whether to shift, load or hold.
   for (genvar k = 0; k < sle_pkg::DEPTH; k++) begin : g_cell
      localparam logic [sle_pkg::CNT_W:0] KV = (sle_pkg::CNT_W + 1)'(k);
      logic signed [sle_pkg::DATA_W-1:0] left_data;
      logic signed [sle_pkg::DATA_W-1:0] right_data;

      // The first cell never shifts up and the last never shifts down.
      if (k == 0) begin : g_first
         assign left_data = req_value;
      end else begin : g_left
         assign left_data = cell_entry[k-1];
      end
      if (k == sle_pkg::DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_entry[k+1];
      end

      always_comb begin
         cell_ctrl[k].value = req_value;
         cell_ctrl[k].sel   = sle_pkg::SEL_HOLD;
         if (accept && ins_ok && KV == pos_x) begin
            cell_ctrl[k].sel = sle_pkg::SEL_VALUE;
         end else if (accept && ins_ok && KV > pos_x && KV <= count_x) begin
            cell_ctrl[k].sel = sle_pkg::SEL_LEFT;
         end else if (accept && del_ok && KV >= pos_x && KV + 1'b1 < count_x) begin
            cell_ctrl[k].sel = sle_pkg::SEL_RIGHT;
         end
      end

      logic raw_match;
      sle_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[k]),
         .left_data  (left_data),
         .right_data (right_data),
         .entry      (cell_entry[k]),
         .match      (raw_match)
      );
      assign cell_match[k] = raw_match && (KV < count_x);
   end

   // Lowest matching cell among the live entries.
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int k = sle_pkg::DEPTH - 1; k >= 0; k--) begin
         if (cell_match[k]) begin
            hit     = 1'b1;
            hit_idx = sle_pkg::IDX_W'(k);
         end
      end
   end

   // Next count and response contents.
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         priority if (ins_ok) begin
            count_in = count_ff + 1'b1;
         end else if (del_ok) begin
            count_in = count_ff - 1'b1;
         end else if (do_clear) begin
            count_in = '0;
         end
      end
      rsp_status_in = status;
      rsp_data_in   = do_read ? cell_entry[rd_addr[sle_pkg::IDX_W-1:0]] : '0;
      rsp_found_in  = (act == sle_pkg::ACT_LOCATE && hit) ? 5'(hit_idx) : '0;
      rsp_valid_in  = accept ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // Capacity register on the APB-style port.
   always_comb begin
      capacity_in = capacity_ff;
      if (psel && penable && pwrite && pready && paddr[2] == sle_pkg::REG_CAPACITY) begin
         capacity_in = pwdata[sle_pkg::CNT_W-1:0];
      end
      prdata = (paddr[2] == sle_pkg::REG_CAPACITY) ?
               {{(32 - sle_pkg::CNT_W){1'b0}}, capacity_ff} : '0;
   end
   assign pready = 1'b1;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         capacity_ff  <= sle_pkg::CNT_W'(32);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload loads only when a transaction is accepted.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

   // The list never holds more entries than there are cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} <= DEPTH_C)
      else $error("entry count exceeds the number of cells");

   // The count moves only with an accepted transaction.
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("entry count changed without a transaction");

   // The response reports the count that the action left behind.
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_entry_count == count_ff && rsp_valid))
      else $error("response count differs from the list count");

   // A successful insert grows the list by exactly one entry.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && ins_ok) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not add one entry");

endmodule

`default_nettype wire

// ===== hdl/sle_cell.sv =====
`default_nettype none

module sle_cell (
   input  wire logic                              clock,
   input  wire sle_pkg::cell_ctrl_type            ctrl,
   input  wire logic signed [sle_pkg::DATA_W-1:0] left_data,
   input  wire logic signed [sle_pkg::DATA_W-1:0] right_data,
   output logic signed [sle_pkg::DATA_W-1:0]      entry,
   output logic                                   match
);

   logic signed [sle_pkg::DATA_W-1:0] entry_ff;
   logic signed [sle_pkg::DATA_W-1:0] entry_in;

   // Choose between holding, taking a neighbor's entry or the new value.
   always_comb begin
      unique case (ctrl.sel)
         sle_pkg::SEL_LEFT:  entry_in = left_data;
         sle_pkg::SEL_RIGHT: entry_in = right_data;
         sle_pkg::SEL_VALUE: entry_in = ctrl.value;
         default:            entry_in = entry_ff;
      endcase
   end

   // The entry is payload and needs no reset.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = (entry_ff == ctrl.value);

endmodule

`default_nettype wire

// ===== tb/tb_sequential_list_engine.sv =====
`timescale 1ns / 100ps

module tb_sequential_list_engine;

   import sle_pkg::*;

   // Action code seven has no meaning and must leave the list untouched.
   localparam logic [2:0] ACT_UNUSED = 3'd7;
   localparam logic [2:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
   localparam int RSP_LATENCY = 1;
   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 115;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [DATA_W-1:0] data;
      logic [4:0]        index;
      logic [CNT_W-1:0]  count;
   } list_result_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [2:0]               req_action;
   logic [POS_W-1:0]         req_position;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_data_out;
   logic [4:0]               rsp_found_index;
   logic [CNT_W-1:0]         rsp_entry_count;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [2:0]               paddr;
   logic [31:0]              pwdata;
   logic [31:0]              prdata;
   logic                     pready;

   // Mirror of the list held by the block.
   logic [DATA_W-1:0] list_cells [DEPTH];
   int                list_len;
   int                list_cap;

   list_result_type pending_results [$];
   int              error_count;
   int              burst_left;
   int              quiet_cycles;
   stall_mode_type  stall_mode;
   int              stall_timer;

   sequential_list_engine u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_found_index (rsp_found_index),
      .rsp_entry_count (rsp_entry_count),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Apply one action to the mirrored list and return the result it should give.
   function automatic list_result_type apply_list_action(input logic [2:0] act,
                                                         input logic [POS_W-1:0] pos,
                                                         input logic [DATA_W-1:0] val);
      list_result_type res;
      int              limit;
      int              p;
      int              k;
      res = '0;
      res.status = ST_OK;
      p = int'(pos);
      limit = (list_cap > DEPTH) ? DEPTH : list_cap;
      case (act)
         ACT_INSERT: begin
            if (p > list_len) begin
               res.status = ST_RANGE;
            end else if (list_len >= limit) begin
               res.status = ST_FULL;
            end else begin
               for (k = list_len; k > p; k--) list_cells[k] = list_cells[k-1];
               list_cells[p] = val;
               list_len++;
            end
         end
         ACT_DELETE: begin
            if (p >= list_len) begin
               res.status = ST_RANGE;
            end else begin
               for (k = p; k + 1 < list_len; k++) list_cells[k] = list_cells[k+1];
               list_len--;
            end
         end
         ACT_LOCATE: begin
            res.status = ST_MISSING;
            for (k = 0; k < list_len; k++) begin
               if (res.status == ST_MISSING && list_cells[k] == val) begin
                  res.status = ST_OK;
                  res.index = k[4:0];
               end
            end
         end
         ACT_GET: begin
            if (p >= list_len) res.status = ST_RANGE;
            else res.data = list_cells[p];
         end
         ACT_PRED: begin
            if (p == 0 || p >= list_len) res.status = ST_RANGE;
            else res.data = list_cells[p-1];
         end
         ACT_SUCC: begin
            if (p + 1 >= list_len) res.status = ST_RANGE;
            else res.data = list_cells[p+1];
         end
         ACT_CLEAR: begin
            list_len = 0;
         end
         default: begin
         end
      endcase
      res.count = list_len[CNT_W-1:0];
      return res;
   endfunction

   // Send one request transaction; the sender runs in bursts, mostly with idle gaps between them.
   task automatic send_item(input logic [2:0] act, input logic [POS_W-1:0] pos,
                            input logic [DATA_W-1:0] val);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_position <= pos;
      req_value <= val;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_results.push_back(apply_list_action(act, pos, val));
      burst_left--;
   endtask

   // Hold the sender off until every outstanding response has been checked.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY + 2) @(posedge clock);
   endtask

   // Write the capacity register, then read it back.
   task automatic write_capacity(input logic [5:0] cap);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CAP_ADDR;
      pwdata <= {26'd0, cap};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      list_cap = int'(cap);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== {26'd0, cap}) begin
         $display("%0t: capacity read back expected %0d actual %0d", $time, cap, prdata);
         error_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Pick a random request; inserts are weighted by insert_bias percent.
   task automatic send_random_item(input int insert_bias);
      int                pick;
      logic [2:0]        act;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] val;
      if ($urandom_range(99) < insert_bias) begin
         act = ACT_INSERT;
      end else begin
         pick = $urandom_range(99);
         if (pick < 30) act = ACT_DELETE;
         else if (pick < 52) act = ACT_LOCATE;
         else if (pick < 68) act = ACT_GET;
         else if (pick < 80) act = ACT_PRED;
         else if (pick < 92) act = ACT_SUCC;
         else if (pick < 97) act = ACT_CLEAR;
         else act = ACT_UNUSED;
      end
      if ($urandom_range(4) == 0) pos = POS_W'($urandom_range(63));
      else pos = POS_W'($urandom_range(0, list_len + 1));
      pick = $urandom_range(7);
      if (pick == 0) begin
         case ($urandom_range(3))
            0: val = 32'h8000_0000;
            1: val = 32'h7fff_ffff;
            2: val = 32'h0000_0000;
            default: val = 32'hffff_ffff;
         endcase
      end else if (pick < 3) begin
         val = $urandom_range(0, 7);
      end else begin
         val = $urandom;
      end
      // Most searches look for a value that is present.
      if (act == ACT_LOCATE && list_len > 0 && $urandom_range(9) < 7)
         val = list_cells[IDX_W'($urandom_range(list_len - 1))];
      send_item(act, pos, val);
   endtask

   // Every action, the field extremes and the range bound cases.
   task automatic test_list_operations();
      send_item(ACT_GET, 6'd0, 32'd0);
      send_item(ACT_INSERT, 6'd0, 32'h7fff_ffff);
      send_item(ACT_INSERT, 6'd2, 32'd9);
      send_item(ACT_INSERT, 6'd1, 32'h8000_0000);
      send_item(ACT_INSERT, 6'd0, 32'd5);
      send_item(ACT_INSERT, 6'd1, 32'd5);
      send_item(ACT_LOCATE, 6'd0, 32'd5);
      send_item(ACT_LOCATE, 6'd63, 32'h8000_0000);
      send_item(ACT_LOCATE, 6'd0, 32'd12345);
      send_item(ACT_GET, 6'd3, 32'd0);
      send_item(ACT_GET, 6'd4, 32'd0);
      send_item(ACT_GET, 6'd63, 32'hffff_ffff);
      send_item(ACT_PRED, 6'd0, 32'd0);
      send_item(ACT_PRED, 6'd1, 32'd0);
      send_item(ACT_PRED, 6'd4, 32'd0);
      send_item(ACT_SUCC, 6'd2, 32'd0);
      send_item(ACT_SUCC, 6'd3, 32'd0);
      send_item(ACT_DELETE, 6'd1, 32'd0);
      send_item(ACT_DELETE, 6'd3, 32'd0);
      send_item(ACT_UNUSED, 6'd63, 32'hffff_ffff);
      send_item(ACT_CLEAR, 6'd0, 32'd0);
      send_item(ACT_GET, 6'd0, 32'd0);
      send_item(ACT_LOCATE, 6'd0, 32'd5);
      wait_for_idle();
   endtask

   // Full list at small capacities, including a capacity lowered below the count.
   task automatic test_capacity_limits();
      write_capacity(6'd0);
      send_item(ACT_INSERT, 6'd0, 32'd1);
      send_item(ACT_INSERT, 6'd1, 32'd1);
      wait_for_idle();
      write_capacity(6'd2);
      send_item(ACT_INSERT, 6'd0, 32'd10);
      send_item(ACT_INSERT, 6'd1, 32'd20);
      send_item(ACT_INSERT, 6'd0, 32'd30);
      wait_for_idle();
      write_capacity(6'd1);
      send_item(ACT_INSERT, 6'd2, 32'd40);
      send_item(ACT_DELETE, 6'd0, 32'd0);
      send_item(ACT_INSERT, 6'd0, 32'd50);
      send_item(ACT_GET, 6'd0, 32'd0);
      wait_for_idle();
   endtask

   // Random traffic over several capacity settings.
   task automatic test_random_traffic();
      int caps [8];
      int phase;
      int n;
      caps = '{32, 5, 0, 63, 1, 32, 17, 32};
      caps[6] = $urandom_range(0, 32);
      for (phase = 0; phase < 8; phase++) begin
         write_capacity(caps[phase][5:0]);
         for (n = 0; n < RANDOM_ITEMS; n++) begin
            send_random_item((caps[phase] == 63) ? 60 : 38);
            // Halfway through one phase the sender waits for the block to drain.
            if (phase == 1 && n == RANDOM_ITEMS / 2) wait_for_idle();
         end
         wait_for_idle();
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] expected,
                              input logic [31:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, expected, actual);
         error_count++;
      end
   endtask

   // Compare each response transaction with the oldest predicted result.
   always @(posedge clock) begin
      list_result_type exp_res;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response with none expected, status %0d", $time, rsp_status);
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            check_field("status", 32'(exp_res.status), 32'(rsp_status));
            check_field("data_out", exp_res.data, rsp_data_out);
            check_field("found_index", 32'(exp_res.index), 32'(rsp_found_index));
            check_field("entry_count", 32'(exp_res.count), 32'(rsp_entry_count));
         end
      end
   end

   // The receiver stalls in modes that change whenever the stall timer runs out.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode <= STALL_NONE;
         stall_timer <= 0;
      end else begin
         if (stall_timer == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(3));
            stall_timer <= $urandom_range(20, 80);
         end else begin
            stall_timer <= stall_timer - 1;
         end
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(3) == 0);
            STALL_PERIODIC: rsp_stall <= (stall_timer % 3 == 0);
            default:        rsp_stall <= ($urandom_range(9) < 7);
         endcase
      end
   end

   // Watchdog on cycles in which no transaction moves.
   always @(posedge clock) begin
      if (reset || psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_INSERT;
      req_position = '0;
      req_value = '0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      error_count = 0;
      burst_left = 0;
      quiet_cycles = 0;
      list_len = 0;
      list_cap = 32;
      for (int k = 0; k < DEPTH; k++) list_cells[k] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_list_operations();
      test_capacity_limits();
      test_random_traffic();
      wait_for_idle();
      repeat (RSP_LATENCY + 4) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/sle_pkg.sv
hdl/sle_cell.sv
hdl/sequential_list_engine.sv
tb/tb_sequential_list_engine.sv
